// File: sv/wrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants of the weighted reservoir sampler.
// ----------------------------------------------------------------------------
package wrs_pkg;

  localparam logic [1:0] OP_STREAM = 2'd0;
  localparam logic [1:0] OP_CLAMP  = 2'd1;
  localparam logic [1:0] OP_FINAL  = 2'd2;

  localparam logic [31:0] MAX_HISTORY_RESET = 32'd20;
  localparam int          DIV_STEPS         = 96;
  localparam int          DIV_CNT_W         = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sample_id;
    logic [31:0] tgt_dens;
    logic [31:0] prop_dens;
    logic [15:0] multiplicity;
    logic [15:0] random_fraction;
  } wrs_in_t;

  typedef struct packed {
    logic        accepted;
    logic        valid_res;
    logic [31:0] chosen_id;
    logic [31:0] chosen_target;
    logic [31:0] chosen_proposal;
    logic [15:0] chosen_multiplicity;
    logic [31:0] total_count;
    logic [47:0] norm_weight;
    logic [63:0] mean_weight;
  } wrs_out_t;

  typedef struct packed {
    logic [31:0] hi;
    logic [63:0] lo;
    logic [63:0] dvs;
    logic        lim48;
  } wrs_div_req_t;

endpackage

// File: sv/weighted_reservoir_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_reservoir_sampler_unit
// Single weighted reservoir: stream candidates, clamp history, finalize.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result appears
// on out_data for one cycle with out_valid, and the receiver cannot stall it.
// A stream rejected for a zero field or a count overflow, a clamp with no
// effect or a zero cap, a finalize that fails its up-front checks, and op 3
// are answered from idle. A stream rejected for a zero weight or an
// overflowing sum runs one product and one divide, any other stream two more
// products and a compare, a clamp that scales the sum two products and one
// divide, and any other finalize one product and two divides. Each divide
// runs on the shared bit-serial divider; products go through one registered
// 32x32 multiplier, one per cycle. busy drops in the cycle the result shows, so
// the next item can be taken at the edge that takes the result.
module weighted_reservoir_sampler_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wrs_pkg::wrs_in_t  in_data,
  output logic              out_valid,
  output wrs_pkg::wrs_out_t out_data,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import wrs_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_W_MUL   = 4'd1;
  localparam logic [3:0] ST_W_DIV   = 4'd2;
  localparam logic [3:0] ST_W_WAIT  = 4'd3;
  localparam logic [3:0] ST_R_LO    = 4'd4;
  localparam logic [3:0] ST_R_HI    = 4'd5;
  localparam logic [3:0] ST_R_CMP   = 4'd6;
  localparam logic [3:0] ST_C_MA    = 4'd7;
  localparam logic [3:0] ST_C_MB    = 4'd8;
  localparam logic [3:0] ST_C_DIV   = 4'd9;
  localparam logic [3:0] ST_C_WAIT  = 4'd10;
  localparam logic [3:0] ST_F_MUL   = 4'd11;
  localparam logic [3:0] ST_F_DIVN  = 4'd12;
  localparam logic [3:0] ST_F_WAITN = 4'd13;
  localparam logic [3:0] ST_F_DIVM  = 4'd14;
  localparam logic [3:0] ST_F_WAITM = 4'd15;

  logic [3:0]  state_r, state_nxt;
  wrs_in_t     cand_r, cand_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic        hold_r, hold_nxt;
  logic [31:0] pid_r, pid_nxt;
  logic [31:0] ptgt_r, ptgt_nxt;
  logic [31:0] pprop_r, pprop_nxt;
  logic [15:0] pmult_r, pmult_nxt;
  logic [63:0] wt_r, wt_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [63:0] w_r, w_nxt;
  logic [63:0] ns_r, ns_nxt;
  logic [63:0] plo_r, plo_nxt;
  logic [63:0] a_r, a_nxt;
  logic [47:0] nw_r, nw_nxt;
  logic [63:0] mul_p_r;
  logic        out_valid_r, out_valid_nxt;
  wrs_out_t    out_r, out_nxt;

  logic         mul_en;
  logic [31:0]  mul_a, mul_b;
  logic         div_start, div_done;
  wrs_div_req_t div_req;
  logic [63:0]  quot;

  logic         emit, acc, fin_op, fin_ok;
  logic [47:0]  nw_out;
  logic [63:0]  mw_out;
  logic [32:0]  cnt_sum;
  logic [64:0]  ns_sum;
  logic [64:0]  lo_sum;
  logic [63:0]  phi;
  logic         take;

  wrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    cap_nxt   = cfg_we ? cfg_wdata : cap_r;
    hold_nxt  = hold_r;
    pid_nxt   = pid_r;
    ptgt_nxt  = ptgt_r;
    pprop_nxt = pprop_r;
    pmult_nxt = pmult_r;
    wt_nxt    = wt_r;
    seen_nxt  = seen_r;
    w_nxt     = w_r;
    ns_nxt    = ns_r;
    plo_nxt   = plo_r;
    a_nxt     = a_r;
    nw_nxt    = nw_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_req   = '0;
    emit      = 1'b0;
    acc       = 1'b0;
    fin_op    = 1'b0;
    fin_ok    = 1'b0;
    nw_out    = '0;
    mw_out    = '0;
    cnt_sum   = {1'b0, seen_r} + {17'd0, cand_r.multiplicity};
    ns_sum    = {1'b0, wt_r} + {1'b0, quot};
    lo_sum    = {1'b0, mul_p_r} + {1'b0, a_r[31:0], 32'd0};
    phi       = mul_p_r + {32'd0, plo_r[63:32]};
    take      = !hold_r || (phi < {16'd0, w_r[63:16]}) ||
                ((phi == {16'd0, w_r[63:16]}) && (plo_r[31:0] < {w_r[15:0], 16'd0}));

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cand_nxt = in_data;
          cnt_sum  = {1'b0, seen_r} + {17'd0, in_data.multiplicity};
          case (in_data.op)
            OP_STREAM: begin
              if (in_data.tgt_dens == '0 || in_data.prop_dens == '0 ||
                  in_data.multiplicity == '0 || cnt_sum[32]) begin
                emit = 1'b1;
              end else begin
                state_nxt = ST_W_MUL;
              end
            end
            OP_CLAMP: begin
              if (cap_r == '0) begin
                hold_nxt  = 1'b0;
                pid_nxt   = '0;
                ptgt_nxt  = '0;
                pprop_nxt = '0;
                pmult_nxt = '0;
                wt_nxt    = '0;
                seen_nxt  = '0;
                emit      = 1'b1;
              end else if (seen_r <= cap_r) begin
                emit = 1'b1;
              end else begin
                state_nxt = ST_C_MA;
              end
            end
            OP_FINAL: begin
              if (!hold_r || seen_r == '0 || wt_r == '0 || ptgt_r == '0) begin
                emit   = 1'b1;
                fin_op = 1'b1;
              end else begin
                state_nxt = ST_F_MUL;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_W_MUL: begin
        mul_en    = 1'b1;
        mul_a     = cand_r.tgt_dens;
        mul_b     = {16'd0, cand_r.multiplicity};
        state_nxt = ST_W_DIV;
      end
      ST_W_DIV: begin
        div_start     = 1'b1;
        div_req.hi    = '0;
        div_req.lo    = {mul_p_r[47:0], 16'd0};
        div_req.dvs   = {32'd0, cand_r.prop_dens};
        div_req.lim48 = 1'b0;
        state_nxt     = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        if (div_done) begin
          if (quot == '0 || ns_sum[64]) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            w_nxt     = quot;
            ns_nxt    = ns_sum[63:0];
            state_nxt = ST_R_LO;
          end
        end
      end
      ST_R_LO: begin
        mul_en    = 1'b1;
        mul_a     = {16'd0, cand_r.random_fraction};
        mul_b     = ns_r[31:0];
        state_nxt = ST_R_HI;
      end
      ST_R_HI: begin
        plo_nxt   = mul_p_r;
        mul_en    = 1'b1;
        mul_a     = {16'd0, cand_r.random_fraction};
        mul_b     = ns_r[63:32];
        state_nxt = ST_R_CMP;
      end
      ST_R_CMP: begin
        if (take) begin
          hold_nxt  = 1'b1;
          pid_nxt   = cand_r.sample_id;
          ptgt_nxt  = cand_r.tgt_dens;
          pprop_nxt = cand_r.prop_dens;
          pmult_nxt = cand_r.multiplicity;
        end
        wt_nxt    = ns_r;
        seen_nxt  = cnt_sum[31:0];
        acc       = 1'b1;
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_C_MA: begin
        mul_en    = 1'b1;
        mul_a     = wt_r[63:32];
        mul_b     = cap_r;
        state_nxt = ST_C_MB;
      end
      ST_C_MB: begin
        a_nxt     = mul_p_r;
        mul_en    = 1'b1;
        mul_a     = wt_r[31:0];
        mul_b     = cap_r;
        state_nxt = ST_C_DIV;
      end
      ST_C_DIV: begin
        div_start     = 1'b1;
        div_req.hi    = a_r[63:32] + {31'd0, lo_sum[64]};
        div_req.lo    = lo_sum[63:0];
        div_req.dvs   = {32'd0, seen_r};
        div_req.lim48 = 1'b0;
        state_nxt     = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (div_done) begin
          wt_nxt   = quot;
          seen_nxt = cap_r;
          if ({16'd0, pmult_r} > cap_r) begin
            pmult_nxt = cap_r[15:0];
          end
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_F_MUL: begin
        mul_en    = 1'b1;
        mul_a     = seen_r;
        mul_b     = ptgt_r;
        state_nxt = ST_F_DIVN;
      end
      ST_F_DIVN: begin
        div_start     = 1'b1;
        div_req.hi    = {16'd0, wt_r[63:48]};
        div_req.lo    = {wt_r[47:0], 16'd0};
        div_req.dvs   = mul_p_r;
        div_req.lim48 = 1'b1;
        state_nxt     = ST_F_WAITN;
      end
      ST_F_WAITN: begin
        if (div_done) begin
          nw_nxt    = quot[47:0];
          state_nxt = ST_F_DIVM;
        end
      end
      ST_F_DIVM: begin
        div_start     = 1'b1;
        div_req.hi    = '0;
        div_req.lo    = wt_r;
        div_req.dvs   = {32'd0, seen_r};
        div_req.lim48 = 1'b0;
        state_nxt     = ST_F_WAITM;
      end
      ST_F_WAITM: begin
        if (div_done) begin
          emit      = 1'b1;
          fin_op    = 1'b1;
          fin_ok    = (nw_r != '0) && (quot != '0);
          nw_out    = nw_r;
          mw_out    = quot;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = emit;
    out_nxt       = out_r;
    if (emit) begin
      out_nxt.accepted            = acc;
      out_nxt.valid_res           = fin_ok;
      out_nxt.chosen_id           = pid_nxt;
      out_nxt.chosen_target       = ptgt_nxt;
      out_nxt.chosen_proposal     = pprop_nxt;
      out_nxt.chosen_multiplicity = pmult_nxt;
      out_nxt.total_count         = seen_nxt;
      out_nxt.norm_weight         = fin_ok ? nw_out : '0;
      out_nxt.mean_weight         = fin_ok ? mw_out : '0;
      if (fin_op && !fin_ok) begin
        out_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= MAX_HISTORY_RESET;
      hold_r      <= 1'b0;
      pid_r       <= '0;
      ptgt_r      <= '0;
      pprop_r     <= '0;
      pmult_r     <= '0;
      wt_r        <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      hold_r      <= hold_nxt;
      pid_r       <= pid_nxt;
      ptgt_r      <= ptgt_nxt;
      pprop_r     <= pprop_nxt;
      pmult_r     <= pmult_nxt;
      wt_r        <= wt_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cand_r <= cand_nxt;
    w_r    <= w_nxt;
    ns_r   <= ns_nxt;
    plo_r  <= plo_nxt;
    a_r    <= a_nxt;
    nw_r   <= nw_nxt;
    out_r  <= out_nxt;
    if (mul_en) begin
      mul_p_r <= mul_a * mul_b;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/wrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_div
// Restoring divider, 96-bit dividend by 64-bit divisor, one quotient bit per
// cycle, quotient saturating at 2^48-1 or 2^64-1.
// ----------------------------------------------------------------------------
module wrs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  wrs_pkg::wrs_div_req_t req,
  output logic                  done,
  output logic [63:0]           quot
);
  import wrs_pkg::*;

  logic                 act_r, act_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [95:0]          dvd_r, dvd_nxt;
  logic [63:0]          rem_r, rem_nxt;
  logic [63:0]          dvs_r, dvs_nxt;
  logic [63:0]          q_r, q_nxt;
  logic                 sat_r, sat_nxt;
  logic                 lim48_r, lim48_nxt;
  logic [64:0]          rs;
  logic [64:0]          diff;
  logic                 ge;
  logic                 top;

  always_comb begin
    act_nxt   = act_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_nxt     = q_r;
    sat_nxt   = sat_r;
    lim48_nxt = lim48_r;
    rs        = {rem_r, dvd_r[95]};
    diff      = rs - {1'b0, dvs_r};
    ge        = (rs >= {1'b0, dvs_r});
    top       = lim48_r ? q_r[47] : q_r[63];
    if (start) begin
      act_nxt   = 1'b1;
      cnt_nxt   = DIV_CNT_W'(DIV_STEPS - 1);
      dvd_nxt   = {req.hi, req.lo};
      rem_nxt   = '0;
      dvs_nxt   = req.dvs;
      q_nxt     = '0;
      sat_nxt   = 1'b0;
      lim48_nxt = req.lim48;
    end else if (act_r) begin
      dvd_nxt = {dvd_r[94:0], 1'b0};
      rem_nxt = ge ? diff[63:0] : rs[63:0];
      if (!sat_r) begin
        if (top) begin
          sat_nxt = 1'b1;
        end else begin
          q_nxt = {q_r[62:0], ge};
        end
      end
      if (cnt_r == '0) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    q_r     <= q_nxt;
    sat_r   <= sat_nxt;
    lim48_r <= lim48_nxt;
  end

  assign done = done_r;
  assign quot = sat_r ? (lim48_r ? {16'h0000, {48{1'b1}}} : {64{1'b1}}) : q_r;

endmodule

// File: sv/wrs_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_check
// Port-level checks of the weighted reservoir sampler, bound to the top level.
// ----------------------------------------------------------------------------
module wrs_check (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input wrs_pkg::wrs_out_t out_data
);

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while busy");

  a_result_caused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result transfer without an accepted item");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither worked on nor answered");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.valid_res) |->
      (out_data.norm_weight == '0 && out_data.mean_weight == '0))
    else $error("weights reported without a valid finalize");

  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accepted) |->
      (out_data.total_count != '0 && !out_data.valid_res))
    else $error("accepted candidate with empty count");

endmodule

bind weighted_reservoir_sampler_unit wrs_check u_wrs_check (.*);
